/* hdl/assert_macros.svh */
// Assertion macros shared by the keyframe table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSTK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define TSTK_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define TSTK_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSTK_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hdl/tstk_pkg.sv */
// Shared widths, codes and the cell control type of the keyframe table.
package tstk_pkg;

    // Fixed field widths of the request and result ports
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 5;
    localparam int KEY_W     = 24;
    localparam int KIND_W    = 3;
    localparam int PAYLOAD_W = 48;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;

    // Parameter defaults
    localparam int DEPTH_DEFAULT          = 32;
    localparam int TIME_BITS_DEFAULT      = 24;
    localparam int MIN_LENGTH_DEFAULT     = 1;
    localparam int DEFAULT_LENGTH_DEFAULT = 10240;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SETLEN  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SLOT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Entry kinds
    localparam logic [KIND_W-1:0] KIND_TIME_SCALE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MAX        = 3'd4;

    // Cell operations broadcast along the chain
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLAMP  = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
    } cell_ctrl_t;

endpackage

/* hdl/tstk_cell.sv */
// One position of the sorted table: holds an entry and trades with its neighbors.
module tstk_cell #(
    parameter int DEPTH     = tstk_pkg::DEPTH_DEFAULT,
    parameter int TIME_BITS = tstk_pkg::TIME_BITS_DEFAULT,
    parameter int INDEX     = 0
) (
    input  logic                           aclk,
    input  tstk_pkg::cell_ctrl_t           ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]     count,
    input  logic [TIME_BITS-1:0]           new_time,
    input  logic [tstk_pkg::KIND_W-1:0]    new_kind,
    input  logic [tstk_pkg::PAYLOAD_W-1:0] new_payload,
    input  logic [TIME_BITS-1:0]           limit,
    input  logic                           left_gt,
    input  logic [TIME_BITS-1:0]           left_time,
    input  logic [tstk_pkg::KIND_W-1:0]    left_kind,
    input  logic [tstk_pkg::PAYLOAD_W-1:0] left_payload,
    input  logic [TIME_BITS-1:0]           right_time,
    input  logic [tstk_pkg::KIND_W-1:0]    right_kind,
    input  logic [tstk_pkg::PAYLOAD_W-1:0] right_payload,
    output logic                           gt,
    output logic                           here,
    output logic                           match,
    output logic [TIME_BITS-1:0]           cur_time,
    output logic [tstk_pkg::KIND_W-1:0]    cur_kind,
    output logic [tstk_pkg::PAYLOAD_W-1:0] cur_payload
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = CNT_W + tstk_pkg::SLOT_W;

    logic [TIME_BITS-1:0]           time_reg,    time_next;
    logic [tstk_pkg::KIND_W-1:0]    kind_reg,    kind_next;
    logic [tstk_pkg::PAYLOAD_W-1:0] payload_reg, payload_next;

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] slot_ext;
    logic             occupied;
    logic             at_slot;

    assign idx_ext  = CMP_W'(INDEX);
    assign cnt_ext  = CMP_W'(count);
    assign slot_ext = CMP_W'(ctrl.slot);
    assign occupied = idx_ext < cnt_ext;
    assign at_slot  = idx_ext == slot_ext;

    // Position flags: entries later than the new time move up by one
    assign gt    = occupied && (new_time < time_reg);
    assign here  = !left_gt && (gt || (idx_ext == cnt_ext));
    assign match = at_slot && (time_reg == new_time);

    // Pick next contents from self, a neighbor or the broadcast entry
    always_comb begin
        time_next    = time_reg;
        kind_next    = kind_reg;
        payload_next = payload_reg;
        case (ctrl.op)
            tstk_pkg::OP_INSERT: begin
                if (left_gt) begin
                    time_next    = left_time;
                    kind_next    = left_kind;
                    payload_next = left_payload;
                end else if (here) begin
                    time_next    = new_time;
                    kind_next    = new_kind;
                    payload_next = new_payload;
                end
            end
            tstk_pkg::OP_REMOVE: begin
                if (occupied && (idx_ext >= slot_ext)) begin
                    time_next    = right_time;
                    kind_next    = right_kind;
                    payload_next = right_payload;
                end
            end
            tstk_pkg::OP_CLAMP: begin
                if (occupied && (time_reg > limit)) begin
                    time_next = limit;
                end
            end
            tstk_pkg::OP_WRITE: begin
                if (at_slot) begin
                    kind_next    = new_kind;
                    payload_next = new_payload;
                end
            end
            default: begin
                time_next    = time_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        time_reg    <= time_next;
        kind_reg    <= kind_next;
        payload_reg <= payload_next;
    end

    assign cur_time    = time_reg;
    assign cur_kind    = kind_reg;
    assign cur_payload = payload_reg;

endmodule

/* hdl/time_sorted_keyframe_table_unit.sv */
// Top level of the time-sorted keyframe table: request decode, sequencer and cell row.
//
// Keeps up to DEPTH keyframes sorted by time in a row of cells; every cell compares
// the request time with its own entry and shifts toward its neighbor when the row acts.
// A request is first captured, then the cell row inserts, removes, overwrites or
// clamps as the result is registered; a replace that changes the time has the row
// remove the old entry and then insert the new one. Each row step waits while the
// result register is held by m_ready. The next request is accepted the cycle after
// the result is registered, so a new request is taken only once the last one is done.
// Table storage has no reset; only positions below the entry count are ever read.
module time_sorted_keyframe_table_unit #(
    parameter int DEPTH          = tstk_pkg::DEPTH_DEFAULT,
    parameter int TIME_BITS      = tstk_pkg::TIME_BITS_DEFAULT,
    parameter int MIN_LENGTH     = tstk_pkg::MIN_LENGTH_DEFAULT,
    parameter int DEFAULT_LENGTH = tstk_pkg::DEFAULT_LENGTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tstk_pkg::CMD_W-1:0]       s_cmd,
    input  logic [tstk_pkg::SLOT_W-1:0]      s_slot,
    input  logic [tstk_pkg::KEY_W-1:0]       s_key_time,
    input  logic [tstk_pkg::KIND_W-1:0]      s_key_kind,
    input  logic [tstk_pkg::PAYLOAD_W-1:0]   s_key_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tstk_pkg::STATUS_W-1:0]    m_status,
    output logic [tstk_pkg::SLOT_W-1:0]      m_placed_at,
    output logic [tstk_pkg::COUNT_W-1:0]     m_entry_count
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = CNT_W + tstk_pkg::SLOT_W;
    localparam logic [TIME_BITS-1:0] MIN_LEN   = TIME_BITS'(MIN_LENGTH);
    localparam logic [TIME_BITS-1:0] RESET_LEN = TIME_BITS'(DEFAULT_LENGTH);
    localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    logic [1:0]                      state_reg,   state_next;
    logic [tstk_pkg::CMD_W-1:0]      cmd_reg,     cmd_next;
    logic [tstk_pkg::SLOT_W-1:0]     slot_reg,    slot_next;
    logic [TIME_BITS-1:0]            time_reg,    time_next;
    logic [tstk_pkg::KIND_W-1:0]     kind_reg,    kind_next;
    logic [tstk_pkg::PAYLOAD_W-1:0]  payload_reg, payload_next;
    logic [CNT_W-1:0]                count_reg,   count_next;
    logic [TIME_BITS-1:0]            length_reg,  length_next;
    logic                            m_valid_reg, m_valid_next;
    logic [tstk_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [tstk_pkg::SLOT_W-1:0]     m_placed_reg, m_placed_next;
    logic [tstk_pkg::COUNT_W-1:0]    m_count_reg,  m_count_next;

    tstk_pkg::cell_ctrl_t ctrl;

    logic [DEPTH-1:0]                gt_vec;
    logic [DEPTH-1:0]                here_vec;
    logic [DEPTH-1:0]                match_vec;
    logic [TIME_BITS-1:0]            cell_time    [DEPTH];
    logic [tstk_pkg::KIND_W-1:0]     cell_kind    [DEPTH];
    logic [tstk_pkg::PAYLOAD_W-1:0]  cell_payload [DEPTH];

    logic                            out_free;
    logic                            entry_ok;
    logic                            slot_ok;
    logic [TIME_BITS-1:0]            new_len;
    logic [IDX_W-1:0]                ins_pos;
    logic [tstk_pkg::SLOT_W-1:0]     ins_placed;
    logic                            fire;

    // Request checks
    assign out_free = !m_valid_reg || m_ready;
    assign entry_ok = (time_reg <= length_reg) && (kind_reg <= tstk_pkg::KIND_MAX) &&
                      !((kind_reg == tstk_pkg::KIND_TIME_SCALE) &&
                        payload_reg[tstk_pkg::PAYLOAD_W-1]);
    assign slot_ok  = CMP_W'(slot_reg) < CMP_W'(count_reg);
    assign new_len  = (time_reg < MIN_LEN) ? MIN_LEN : time_reg;

    // Encode the one-hot insertion point
    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (here_vec[i]) begin
                ins_pos = ins_pos | IDX_W'(i);
            end
        end
    end
    assign ins_placed = tstk_pkg::SLOT_W'(ins_pos);

    // Sequencer: capture, run the cell row, post the result
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        time_next     = time_reg;
        kind_next     = kind_reg;
        payload_next  = payload_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        m_status_next = m_status_reg;
        m_placed_next = m_placed_reg;
        ctrl.op       = tstk_pkg::OP_HOLD;
        ctrl.slot     = slot_reg;
        fire          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_cmd;
                    slot_next    = s_slot;
                    time_next    = TIME_BITS'(s_key_time);
                    kind_next    = s_key_kind;
                    payload_next = s_key_payload;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    m_status_next = tstk_pkg::ST_OK;
                    m_placed_next = '0;
                    fire          = 1'b1;
                    case (cmd_reg)
                        tstk_pkg::CMD_INSERT: begin
                            if (!entry_ok) begin
                                m_status_next = tstk_pkg::ST_INVALID;
                            end else if (count_reg == FULL_CNT) begin
                                m_status_next = tstk_pkg::ST_FULL;
                            end else begin
                                ctrl.op       = tstk_pkg::OP_INSERT;
                                count_next    = count_reg + CNT_W'(1);
                                m_placed_next = ins_placed;
                            end
                        end
                        tstk_pkg::CMD_REMOVE: begin
                            if (!slot_ok) begin
                                m_status_next = tstk_pkg::ST_SLOT;
                            end else begin
                                ctrl.op    = tstk_pkg::OP_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        tstk_pkg::CMD_REPLACE: begin
                            if (!slot_ok) begin
                                m_status_next = tstk_pkg::ST_SLOT;
                            end else if (!entry_ok) begin
                                m_status_next = tstk_pkg::ST_INVALID;
                            end else if (|match_vec) begin
                                ctrl.op       = tstk_pkg::OP_WRITE;
                                m_placed_next = slot_reg;
                            end else begin
                                // drop the old entry now, insert next cycle
                                ctrl.op    = tstk_pkg::OP_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                                fire       = 1'b0;
                            end
                        end
                        default: begin
                            ctrl.op     = tstk_pkg::OP_CLAMP;
                            length_next = new_len;
                        end
                    endcase
                    state_next = fire ? S_IDLE : S_INS;
                end
            end
            S_INS: begin
                if (out_free) begin
                    ctrl.op       = tstk_pkg::OP_INSERT;
                    count_next    = count_reg + CNT_W'(1);
                    m_status_next = tstk_pkg::ST_OK;
                    m_placed_next = ins_placed;
                    fire          = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            m_count_next = tstk_pkg::COUNT_W'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            length_reg  <= RESET_LEN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        time_reg     <= time_next;
        kind_reg     <= kind_next;
        payload_reg  <= payload_next;
        m_status_reg <= m_status_next;
        m_placed_reg <= m_placed_next;
        m_count_reg  <= m_count_next;
    end

    // Row of cells, each linked to its left and right neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                           l_gt;
        logic [TIME_BITS-1:0]           l_time;
        logic [tstk_pkg::KIND_W-1:0]    l_kind;
        logic [tstk_pkg::PAYLOAD_W-1:0] l_payload;
        logic [TIME_BITS-1:0]           r_time;
        logic [tstk_pkg::KIND_W-1:0]    r_kind;
        logic [tstk_pkg::PAYLOAD_W-1:0] r_payload;

        if (g == 0) begin : g_first
            assign l_gt      = 1'b0;
            assign l_time    = '0;
            assign l_kind    = '0;
            assign l_payload = '0;
        end else begin : g_mid_l
            assign l_gt      = gt_vec[g-1];
            assign l_time    = cell_time[g-1];
            assign l_kind    = cell_kind[g-1];
            assign l_payload = cell_payload[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign r_time    = '0;
            assign r_kind    = '0;
            assign r_payload = '0;
        end else begin : g_mid_r
            assign r_time    = cell_time[g+1];
            assign r_kind    = cell_kind[g+1];
            assign r_payload = cell_payload[g+1];
        end

        tstk_cell #(
            .DEPTH     (DEPTH),
            .TIME_BITS (TIME_BITS),
            .INDEX     (g)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (ctrl),
            .count         (count_reg),
            .new_time      (time_reg),
            .new_kind      (kind_reg),
            .new_payload   (payload_reg),
            .limit         (new_len),
            .left_gt       (l_gt),
            .left_time     (l_time),
            .left_kind     (l_kind),
            .left_payload  (l_payload),
            .right_time    (r_time),
            .right_kind    (r_kind),
            .right_payload (r_payload),
            .gt            (gt_vec[g]),
            .here          (here_vec[g]),
            .match         (match_vec[g]),
            .cur_time      (cell_time[g]),
            .cur_kind      (cell_kind[g]),
            .cur_payload   (cell_payload[g])
        );
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_placed_at   = m_placed_reg;
    assign m_entry_count = m_count_reg;

    // Checks on the sequencer and the row
    `TSTK_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > FULL_CNT,
        "entry count above table depth")
    `TSTK_ASSERT(a_ins_after_replace, aclk, aresetn,
        (state_reg == S_INS) |-> (cmd_reg == tstk_pkg::CMD_REPLACE),
        "second insert phase outside a replace")
    `TSTK_ASSERT(a_ins_has_room, aclk, aresetn,
        (state_reg == S_INS) |-> (count_reg < FULL_CNT),
        "re-sort insert with a full table")
    `TSTK_ASSERT(a_one_slot, aclk, aresetn, $onehot0(here_vec),
        "more than one insertion point in the row")

endmodule

/* tb/time_sorted_keyframe_table_unit_tb.sv */
// Self-checking testbench for the time-sorted keyframe table, with its own table predictor.
module time_sorted_keyframe_table_unit_tb;
    import tstk_pkg::*;

    localparam int TABLE_DEPTH    = DEPTH_DEFAULT;
    localparam int MIN_LEN        = MIN_LENGTH_DEFAULT;
    localparam int START_LEN      = DEFAULT_LENGTH_DEFAULT;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 250;

    // Entry kinds beside the two the package names
    localparam logic [KIND_W-1:0] KIND_CUT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FADE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPAWN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRIGGER  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD_LOW  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BAD_HIGH = 3'd7;

    localparam logic [PAYLOAD_W-1:0] PAY_NEG  = 48'h8000_0000_0000;
    localparam logic [PAYLOAD_W-1:0] PAY_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0]     TIME_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SLOT_W-1:0]    slot;
        logic [KEY_W-1:0]     key_time;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   placed_at;
        logic [COUNT_W-1:0]  entry_count;
    } outcome_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    logic [SLOT_W-1:0]    s_slot;
    logic [KEY_W-1:0]     s_key_time;
    logic [KIND_W-1:0]    s_key_kind;
    logic [PAYLOAD_W-1:0] s_key_payload;
    logic                 m_valid;
    logic                 m_ready;
    logic [STATUS_W-1:0]  m_status;
    logic [SLOT_W-1:0]    m_placed_at;
    logic [COUNT_W-1:0]   m_entry_count;

    // Predicted table contents
    logic [KEY_W-1:0]     tl_time    [TABLE_DEPTH];
    logic [KIND_W-1:0]    tl_kind    [TABLE_DEPTH];
    logic [PAYLOAD_W-1:0] tl_payload [TABLE_DEPTH];
    int                   tl_count  = 0;
    logic [KEY_W-1:0]     tl_length = KEY_W'(START_LEN);

    outcome_t table_outcome_q[$];
    outcome_t due_outcome;
    int       mismatch_count = 0;
    int       quiet_cycles   = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    bit       holdoff_req    = 1'b0;

    time_sorted_keyframe_table_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_slot        (s_slot),
        .s_key_time    (s_key_time),
        .s_key_kind    (s_key_kind),
        .s_key_payload (s_key_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_placed_at   (m_placed_at),
        .m_entry_count (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Entry rules: time within the timeline, known kind, no negative time scale
    function automatic bit entry_ok(logic [KEY_W-1:0] t, logic [KIND_W-1:0] k,
                                    logic [PAYLOAD_W-1:0] p);
        return !(t > tl_length || k > KIND_MAX ||
                 (k == KIND_TIME_SCALE && p[PAYLOAD_W-1]));
    endfunction

    // Drop the entry at pos and close the gap
    function automatic void close_gap(int pos);
        for (int i = pos; i + 1 < tl_count; i++) begin
            tl_time[i]    = tl_time[i+1];
            tl_kind[i]    = tl_kind[i+1];
            tl_payload[i] = tl_payload[i+1];
        end
        tl_count--;
    endfunction

    // Stable insert: after every entry with an equal time
    function automatic int place_sorted(logic [KEY_W-1:0] t, logic [KIND_W-1:0] k,
                                        logic [PAYLOAD_W-1:0] p);
        int pos;
        pos = tl_count;
        for (int i = 0; i < tl_count; i++) begin
            if (t < tl_time[i]) begin
                pos = i;
                break;
            end
        end
        for (int i = tl_count; i > pos; i--) begin
            tl_time[i]    = tl_time[i-1];
            tl_kind[i]    = tl_kind[i-1];
            tl_payload[i] = tl_payload[i-1];
        end
        tl_time[pos]    = t;
        tl_kind[pos]    = k;
        tl_payload[pos] = p;
        tl_count++;
        return pos;
    endfunction

    // Apply one request to the predicted table and return its outcome.
    // TIME_BITS equals the port width, so times need no masking.
    function automatic outcome_t table_apply(request_t r);
        outcome_t         o;
        logic [KEY_W-1:0] len;
        o = '0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_INSERT: begin
                if (!entry_ok(r.key_time, r.kind, r.payload)) o.status = ST_INVALID;
                else if (tl_count >= TABLE_DEPTH) o.status = ST_FULL;
                else o.placed_at = SLOT_W'(place_sorted(r.key_time, r.kind, r.payload));
            end
            CMD_REMOVE: begin
                if (r.slot >= tl_count) o.status = ST_SLOT;
                else close_gap(r.slot);
            end
            CMD_REPLACE: begin
                if (r.slot >= tl_count) begin
                    o.status = ST_SLOT;
                end else if (!entry_ok(r.key_time, r.kind, r.payload)) begin
                    o.status = ST_INVALID;
                end else if (tl_time[r.slot] == r.key_time) begin
                    tl_kind[r.slot]    = r.kind;
                    tl_payload[r.slot] = r.payload;
                    o.placed_at        = r.slot;
                end else begin
                    close_gap(r.slot);
                    o.placed_at = SLOT_W'(place_sorted(r.key_time, r.kind, r.payload));
                end
            end
            CMD_SETLEN: begin
                len = (r.key_time < KEY_W'(MIN_LEN)) ? KEY_W'(MIN_LEN) : r.key_time;
                for (int i = 0; i < tl_count; i++) begin
                    if (tl_time[i] > len) tl_time[i] = len;
                end
                tl_length = len;
            end
        endcase
        o.entry_count = COUNT_W'(tl_count);
        return o;
    endfunction

    function automatic request_t keyframe_req(logic [CMD_W-1:0] cmd, int slot,
                                              logic [KEY_W-1:0] t, logic [KIND_W-1:0] kind,
                                              logic [PAYLOAD_W-1:0] pay);
        request_t r;
        r.cmd      = cmd;
        r.slot     = SLOT_W'(slot);
        r.key_time = t;
        r.kind     = kind;
        r.payload  = pay;
        return r;
    endfunction

    // Offer one request, hold it until accepted, then predict its outcome
    task automatic send_request(input request_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_cmd         = r.cmd;
        s_slot        = r.slot;
        s_key_time    = r.key_time;
        s_key_kind    = r.kind;
        s_key_payload = r.payload;
        do @(posedge aclk); while (!s_ready);
        table_outcome_q.push_back(table_apply(r));
    endtask

    // Draw a mostly well-formed request from the current table state
    task automatic draw_request(output request_t r);
        int roll;
        int ins_pct;
        r = '0;
        ins_pct = (tl_count < 6) ? 60 : ((tl_count > 28) ? 25 : 42);
        roll = $urandom_range(99);
        if (roll < 10) r.cmd = CMD_SETLEN;
        else if (roll < 10 + ins_pct) r.cmd = CMD_INSERT;
        else if (roll < 10 + ins_pct + (90 - ins_pct) / 2) r.cmd = CMD_REMOVE;
        else r.cmd = CMD_REPLACE;

        if (tl_count > 0 && $urandom_range(99) < 88) r.slot = SLOT_W'($urandom_range(tl_count - 1));
        else r.slot = SLOT_W'($urandom_range(31));

        r.kind    = ($urandom_range(99) < 88) ? KIND_W'($urandom_range(KIND_MAX))
                                              : KIND_W'($urandom_range(KIND_BAD_HIGH, KIND_BAD_LOW));
        r.payload = {16'($urandom), 32'($urandom)};

        roll = $urandom_range(99);
        if (r.cmd == CMD_SETLEN) begin
            if (roll < 10) r.key_time = '0;
            else if (roll < 20) r.key_time = TIME_MAX;
            else if (roll < 60) r.key_time = KEY_W'($urandom);
            else r.key_time = KEY_W'($urandom_range(16000, 1000));
        end else if (r.cmd == CMD_REPLACE && r.slot < tl_count && roll < 25) begin
            r.key_time = tl_time[r.slot];
        end else if (tl_count > 0 && roll < 40) begin
            r.key_time = tl_time[$urandom_range(tl_count - 1)];
        end else if (roll < 48) begin
            r.key_time = tl_length;
        end else if (roll < 54) begin
            r.key_time = tl_length + 1'b1;
        end else if (roll < 62) begin
            r.key_time = KEY_W'($urandom);
        end else begin
            r.key_time = KEY_W'($urandom_range(tl_length));
        end
    endtask

    // Field extremes, every command and each entry and slot rejection rule
    task automatic test_directed();
        send_request(keyframe_req(CMD_REMOVE, 0, '0, KIND_CUT, '0));
        send_request(keyframe_req(CMD_REPLACE, 0, 24'd10, KIND_FADE, '0));
        send_request(keyframe_req(CMD_INSERT, 0, '0, KIND_CUT, '0));
        send_request(keyframe_req(CMD_INSERT, 31, tl_length, KIND_TRIGGER, PAY_ONES));
        send_request(keyframe_req(CMD_INSERT, 0, tl_length + 1'b1, KIND_CUT, '0));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd5, KIND_BAD_LOW, '0));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd5, KIND_BAD_HIGH, '0));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd300, KIND_TIME_SCALE, PAY_NEG));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd300, KIND_TIME_SCALE, ~PAY_NEG));
        // equal times land after the ones already stored
        send_request(keyframe_req(CMD_INSERT, 0, 24'd300, KIND_FADE, 48'h1234_5678_9ABC));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd300, KIND_SPAWN, 48'hA5A5_5A5A_0F0F));
        send_request(keyframe_req(CMD_REPLACE, 2, 24'd300, KIND_TRIGGER, 48'h0000_0000_0042));
        send_request(keyframe_req(CMD_REPLACE, 0, 24'd300, KIND_CUT, 48'h0000_0000_0077));
        send_request(keyframe_req(CMD_REPLACE, 4, 24'd50, KIND_FADE, 48'h0000_0000_0099));
        send_request(keyframe_req(CMD_REPLACE, 1, 24'd60, KIND_BAD_HIGH, '0));
        // slot is checked ahead of the entry
        send_request(keyframe_req(CMD_REPLACE, 9, 24'd60, KIND_BAD_HIGH, '0));
        send_request(keyframe_req(CMD_REPLACE, 31, 24'd60, KIND_CUT, '0));
        // zero length rounds up to the minimum and clamps every entry later than it
        send_request(keyframe_req(CMD_SETLEN, 0, '0, KIND_CUT, '0));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd2, KIND_CUT, '0));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd1, KIND_SPAWN, 48'h0000_0000_0001));
        send_request(keyframe_req(CMD_SETLEN, 0, TIME_MAX, KIND_CUT, '0));
        send_request(keyframe_req(CMD_INSERT, 0, TIME_MAX, KIND_TRIGGER, PAY_ONES));
        send_request(keyframe_req(CMD_REMOVE, 0, '0, KIND_CUT, '0));
        send_request(keyframe_req(CMD_REMOVE, tl_count - 1, '0, KIND_CUT, '0));
        send_request(keyframe_req(CMD_REMOVE, tl_count, '0, KIND_CUT, '0));
    endtask

    // Fill the table to capacity, hit the full case, then empty it
    task automatic test_fill_and_drain();
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] pay;
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        send_request(keyframe_req(CMD_SETLEN, 0, 24'd20000, KIND_CUT, '0));
        while (tl_count < TABLE_DEPTH) begin
            kind = KIND_W'($urandom_range(KIND_MAX));
            pay  = {16'($urandom), 32'($urandom)} & ~PAY_NEG;
            send_request(keyframe_req(CMD_INSERT, 0, KEY_W'($urandom_range(20000)), kind, pay));
        end
        send_request(keyframe_req(CMD_INSERT, 0, 24'd100, KIND_FADE, '0));
        send_request(keyframe_req(CMD_INSERT, 0, 24'd100, KIND_BAD_HIGH, '0));
        send_request(keyframe_req(CMD_REPLACE, TABLE_DEPTH - 1, '0, KIND_SPAWN, PAY_ONES));
        send_request(keyframe_req(CMD_REPLACE, 0, tl_time[0], KIND_TRIGGER, '0));
        while (tl_count > 0) begin
            send_request(keyframe_req(CMD_REMOVE, $urandom_range(tl_count - 1), '0,
                                      KIND_CUT, '0));
        end
        send_request(keyframe_req(CMD_REMOVE, 0, '0, KIND_CUT, '0));
    endtask

    // Random requests under each idling pattern
    task automatic test_random_phases();
        request_t req;
        int       idle_pct  [4] = '{0, 67, 0, 32};
        int       stall_pct [4] = '{0, 0, 67, 32};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            repeat (RANDOM_ITEMS) begin
                draw_request(req);
                send_request(req);
            end
        end
    endtask

    // Hold off the result side so the block fills and stalls its input
    task automatic test_backpressure();
        request_t req;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 1'b1;
        repeat (24) begin
            draw_request(req);
            send_request(req);
        end
    endtask

    // Drive the result-side ready, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_req) begin
                m_ready = 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
                holdoff_req = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Match each result against the oldest predicted outcome
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (table_outcome_q.size() == 0) begin
                $error("result with no request outstanding: m_status %0d", m_status);
                mismatch_count++;
            end else begin
                due_outcome = table_outcome_q.pop_front();
                check_field("m_status", due_outcome.status, m_status);
                check_field("m_placed_at", due_outcome.placed_at, m_placed_at);
                check_field("m_entry_count", due_outcome.entry_count, m_entry_count);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = CMD_INSERT;
        s_slot        = '0;
        s_key_time    = '0;
        s_key_kind    = KIND_CUT;
        s_key_payload = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_phases();
        test_backpressure();

        // drop valid, then wait for every outstanding result
        @(negedge aclk);
        s_valid = 1'b0;
        while (table_outcome_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
